FILE: rtl/vphc_pkg.sv
// Package for the VoIP packet header classifier.
// Holds the beat and summary structs, register, class and status codes and constants.
// No dependencies; every other rtl file imports it.
package vphc_pkg;

    // Limits of the Call-ID value length and of the frame position counter.
    localparam int unsigned MAX_CALL_ID_LEN_DEF = 255;
    localparam int unsigned MAX_FRAME_BYTES_DEF = 65535;

    // Reset values of the configuration registers.
    localparam logic [15:0] SIP_PORT_RESET      = 16'd5060;
    localparam logic [15:0] RTP_PORT_LOW_RESET  = 16'd16384;
    localparam logic [15:0] RTP_PORT_HIGH_RESET = 16'd32768;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SIP_PORT      = 2'd0;
    localparam logic [1:0] CFG_RTP_PORT_LOW  = 2'd1;
    localparam logic [1:0] CFG_RTP_PORT_HIGH = 2'd2;

    // Protocol class codes.
    localparam logic [1:0] CLASS_SIP     = 2'd0;
    localparam logic [1:0] CLASS_RTP     = 2'd1;
    localparam logic [1:0] CLASS_UNKNOWN = 2'd2;

    // Call-ID status codes.
    localparam logic [1:0] STATUS_NONE      = 2'd0;
    localparam logic [1:0] STATUS_FOUND     = 2'd1;
    localparam logic [1:0] STATUS_TRUNCATED = 2'd2;
    localparam logic [1:0] STATUS_NO_CRLF   = 2'd3;

    // Header layout and byte constants.
    localparam logic [15:0] POS_IHL       = 16'd14;
    localparam logic [15:0] POS_SRC_FIRST = 16'd26;
    localparam logic [15:0] POS_SRC_LAST  = 16'd29;
    localparam logic [15:0] POS_DST_FIRST = 16'd30;
    localparam logic [15:0] POS_DST_LAST  = 16'd33;
    localparam logic [15:0] UDP_HDR_BYTES = 16'd8;
    localparam logic [63:0] CALL_ID_TAG   = 64'h43616C6C2D49443A;
    localparam logic [7:0]  BYTE_CR       = 8'h0D;
    localparam logic [7:0]  BYTE_LF       = 8'h0A;
    localparam logic [19:0] US_PER_SEC    = 20'd1000000;

    // Call-ID search phases.
    typedef enum logic [2:0] {
        PHASE_SEARCH = 3'b001,
        PHASE_VALUE  = 3'b010,
        PHASE_DONE   = 3'b100
    } phase_t;

    // One input beat: a frame byte with its side information.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic        last_byte;
        logic [15:0] wire_length;
        logic [31:0] ts_seconds;
        logic [19:0] ts_microseconds;
    } in_beat_t;

    // One frame summary.
    typedef struct packed {
        logic [63:0] timestamp_us;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [15:0] frame_size;
        logic [1:0]  protocol_class;
        logic [15:0] rtp_sequence;
        logic [31:0] rtp_time;
        logic [15:0] call_id_offset;
        logic [7:0]  call_id_length;
        logic [1:0]  call_id_status;
    } summary_t;

    // Configuration register set.
    typedef struct packed {
        logic [15:0] sip_port;
        logic [15:0] rtp_port_low;
        logic [15:0] rtp_port_high;
    } cfg_t;

    // Per-frame state that the summary is built from.
    typedef struct packed {
        logic [63:0] frame_time;
        logic [15:0] frame_length;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] port_pair;
        logic [47:0] rtp_fields;
        phase_t      phase;
        logic [15:0] value_start;
        logic [7:0]  value_count;
        logic        truncated;
    } frame_view_t;

endpackage

FILE: rtl/voip_packet_header_classifier.sv
// Top level of the VoIP packet header classifier: input register, configuration registers.
// Depends on vphc_pkg, vphc_frame_parser and vphc_summary_reg.
//
//   channel  | handshake            | payload
//   ---------+----------------------+----------------------------------
//   in       | in_valid / in_ready  | in_data   (in_beat_t, one byte)
//   out      | out_valid / out_ready| out_data  (summary_t, per frame)
//   cfg      | cfg_we               | cfg_index, cfg_data (16 bits)
//
// One byte beat is taken every cycle while no final beat is held; out_valid rises when the
// summary of a frame's final beat loads from the parser into the output register.
// The rate is set by the single pass from the input register through the parser.
// Reset clears the frame state and loads the default ports; no clearing pass is needed.
// Only a final beat stalls: it waits in the input register while a summary is still held.
module voip_packet_header_classifier
    import vphc_pkg::*;
#(
    parameter int unsigned MAX_CALL_ID_LEN = MAX_CALL_ID_LEN_DEF,
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_beat_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output summary_t    out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    logic        in_valid_reg, in_valid_next;
    in_beat_t    in_beat_reg;
    cfg_t        cfg_reg, cfg_next;
    logic        out_free;
    logic        advance;
    frame_view_t view;

    // The held beat moves on unless it is final and the summary slot is busy.
    assign advance = in_valid_reg && (!in_beat_reg.last_byte || out_free);
    assign in_ready = !in_valid_reg || advance;
    assign in_valid_next = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_beat_reg <= in_data;
        end
    end

    // Configuration registers; indexes past the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SIP_PORT:      cfg_next.sip_port = cfg_data;
                CFG_RTP_PORT_LOW:  cfg_next.rtp_port_low = cfg_data;
                CFG_RTP_PORT_HIGH: cfg_next.rtp_port_high = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{sip_port: SIP_PORT_RESET, rtp_port_low: RTP_PORT_LOW_RESET,
                         rtp_port_high: RTP_PORT_HIGH_RESET};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Byte parser.
    vphc_frame_parser #(
        .MAX_CALL_ID_LEN (MAX_CALL_ID_LEN),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .beat    (in_beat_reg),
        .advance (advance),
        .view    (view)
    );

    // Summary formatting and output register.
    vphc_summary_reg u_summary (
        .clk       (clk),
        .rst_n     (rst_n),
        .view      (view),
        .cfg       (cfg_reg),
        .load      (advance && in_beat_reg.last_byte),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .out_free  (out_free)
    );

`ifndef SYNTH
    // A final beat that moves on always leaves a summary behind.
    a_summary_follows_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && in_beat_reg.last_byte |=> out_valid)
        else $error("final beat left no summary");

    // RTP fields are zero for every other class.
    a_rtp_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.protocol_class != CLASS_RTP |->
            out_data.rtp_sequence == 16'd0 && out_data.rtp_time == 32'd0)
        else $error("RTP fields set on a non-RTP summary");

    // A Call-ID report only comes with a SIP class and within the length limit.
    a_call_id_sip_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.call_id_status != STATUS_NONE |->
            out_data.protocol_class == CLASS_SIP &&
            out_data.call_id_length <= 8'(MAX_CALL_ID_LEN))
        else $error("Call-ID report on a non-SIP summary or over the limit");
`endif

endmodule

FILE: rtl/vphc_frame_parser.sv
// Frame parser: tracks the byte position and extracts header fields and the Call-ID.
// Depends on vphc_pkg. Presents the frame state as updated by the current beat.
module vphc_frame_parser
    import vphc_pkg::*;
#(
    parameter int unsigned MAX_CALL_ID_LEN = MAX_CALL_ID_LEN_DEF,
    parameter int unsigned MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  in_beat_t    beat,
    input  logic        advance,
    output frame_view_t view
);

    logic [15:0] pos_reg, pos_next;
    logic [3:0]  hw_reg, hw_next;
    logic [63:0] window_reg, window_next;
    frame_view_t view_reg, view_next;

    logic [51:0] ts_product;
    logic [63:0] new_time;

    // Capture time in microseconds, a 32 by 20 bit constant product.
    assign ts_product = {20'd0, beat.ts_seconds} * {32'd0, US_PER_SEC};
    assign new_time   = {12'd0, ts_product} + {44'd0, beat.ts_microseconds};

    // Apply one byte to the frame state.
    always_comb
    begin
        logic [15:0] pos;
        logic [15:0] base_pos;
        logic [3:0]  base_hw;
        logic [63:0] base_window;
        logic [15:0] udp;
        logic [15:0] pay;
        logic [15:0] pd;
        logic [15:0] rd;
        logic [1:0]  sel_a;
        logic [1:0]  sel_p;
        logic [2:0]  sel_r;
        logic [7:0]  b;
        logic        prev_cr;
        logic [1:0]  n_count;
        logic [8:0]  sum;

        b = beat.data_byte;
        sel_a = 2'd0;
        sel_p = 2'd0;
        sel_r = 3'd0;
        pd = 16'd0;
        rd = 16'd0;
        prev_cr = 1'b0;
        n_count = 2'd0;
        sum = 9'd0;

        // A first byte starts a fresh frame and samples time and length.
        if (beat.first_byte)
        begin
            base_pos = 16'd0;
            base_hw = 4'd0;
            base_window = 64'd0;
            view_next.frame_time = new_time;
            view_next.frame_length = beat.wire_length;
            view_next.src_addr = 32'd0;
            view_next.dst_addr = 32'd0;
            view_next.port_pair = 32'd0;
            view_next.rtp_fields = 48'd0;
            view_next.phase = PHASE_SEARCH;
            view_next.value_start = 16'd0;
            view_next.value_count = 8'd0;
            view_next.truncated = 1'b0;
        end
        else
        begin
            base_pos = pos_reg;
            base_hw = hw_reg;
            base_window = window_reg;
            view_next = view_reg;
        end

        pos = base_pos;
        pos_next = base_pos;
        hw_next = base_hw;
        window_next = base_window;
        udp = 16'd0;
        pay = 16'd0;

        if (base_pos < 16'(MAX_FRAME_BYTES))
        begin
            pos_next = base_pos + 16'd1;

            // IPv4 header length and addresses.
            if (pos == POS_IHL)
            begin
                hw_next = b[3:0];
            end
            if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST)
            begin
                sel_a = 2'(POS_SRC_LAST - pos);
                view_next.src_addr[{sel_a, 3'b000} +: 8] = b;
            end
            if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST)
            begin
                sel_a = 2'(POS_DST_LAST - pos);
                view_next.dst_addr[{sel_a, 3'b000} +: 8] = b;
            end

            // UDP ports sit where the header length places them.
            udp = POS_IHL + {10'd0, hw_next, 2'b00};
            pay = udp + UDP_HDR_BYTES;
            pd = pos - udp;
            if (pos >= udp && pd < 16'd4)
            begin
                sel_p = 2'(16'd3 - pd);
                view_next.port_pair[{sel_p, 3'b000} +: 8] = b;
            end

            // Payload: RTP fields and the Call-ID search.
            if (pos >= pay)
            begin
                rd = pos - pay;
                if (rd >= 16'd2 && rd <= 16'd7)
                begin
                    sel_r = 3'(16'd7 - rd);
                    view_next.rtp_fields[{sel_r, 3'b000} +: 8] = b;
                end

                if (view_next.phase == PHASE_VALUE)
                begin
                    prev_cr = (base_window[7:0] == BYTE_CR) &&
                              (view_next.value_start <= pos - 16'd1);
                    if (prev_cr && b == BYTE_LF)
                    begin
                        view_next.phase = PHASE_DONE;
                    end
                    else
                    begin
                        // A held CR and the current byte may both count.
                        n_count = {1'b0, prev_cr} + {1'b0, b != BYTE_CR};
                        sum = {1'b0, view_next.value_count} + {7'd0, n_count};
                        if (sum > 9'(MAX_CALL_ID_LEN))
                        begin
                            view_next.value_count = 8'(MAX_CALL_ID_LEN);
                            view_next.truncated = 1'b1;
                        end
                        else
                        begin
                            view_next.value_count = sum[7:0];
                        end
                    end
                end

                window_next = {base_window[55:0], b};
                if (view_next.phase == PHASE_SEARCH && window_next == CALL_ID_TAG)
                begin
                    view_next.phase = PHASE_VALUE;
                    view_next.value_start = pos + 16'd1;
                end
            end
        end
    end

    assign view = view_next;

    // Frame state registers; a final byte leaves only time and length.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 16'd0;
            hw_reg <= 4'd0;
            window_reg <= 64'd0;
            view_reg <= '{frame_time: 64'd0, frame_length: 16'd0, src_addr: 32'd0,
                          dst_addr: 32'd0, port_pair: 32'd0, rtp_fields: 48'd0,
                          phase: PHASE_SEARCH, value_start: 16'd0, value_count: 8'd0,
                          truncated: 1'b0};
        end
        else if (advance)
        begin
            if (beat.last_byte)
            begin
                pos_reg <= 16'd0;
                hw_reg <= 4'd0;
                window_reg <= 64'd0;
                view_reg <= '{frame_time: view_next.frame_time,
                              frame_length: view_next.frame_length,
                              src_addr: 32'd0, dst_addr: 32'd0, port_pair: 32'd0,
                              rtp_fields: 48'd0, phase: PHASE_SEARCH,
                              value_start: 16'd0, value_count: 8'd0, truncated: 1'b0};
            end
            else
            begin
                pos_reg <= pos_next;
                hw_reg <= hw_next;
                window_reg <= window_next;
                view_reg <= view_next;
            end
        end
    end

endmodule

FILE: rtl/vphc_summary_reg.sv
// Summary stage: classifies the frame, formats the summary and holds it for the consumer.
// Depends on vphc_pkg; fed by vphc_frame_parser through the top level.
module vphc_summary_reg
    import vphc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  frame_view_t view,
    input  cfg_t        cfg,
    input  logic        load,
    input  logic        out_ready,
    output logic        out_valid,
    output summary_t    out_data,
    output logic        out_free
);

    logic     out_valid_reg, out_valid_next;
    summary_t out_data_reg, out_data_next;

    // Class decision and field formatting.
    always_comb
    begin
        logic [15:0] sport;
        logic [15:0] dport;
        logic [1:0]  cls;

        sport = view.port_pair[31:16];
        dport = view.port_pair[15:0];
        priority if (sport == cfg.sip_port || dport == cfg.sip_port)
        begin
            cls = CLASS_SIP;
        end
        else if (sport >= cfg.rtp_port_low && sport <= cfg.rtp_port_high)
        begin
            cls = CLASS_RTP;
        end
        else
        begin
            cls = CLASS_UNKNOWN;
        end

        out_data_next.timestamp_us = view.frame_time;
        out_data_next.source_address = view.src_addr;
        out_data_next.destination_address = view.dst_addr;
        out_data_next.source_port = sport;
        out_data_next.destination_port = dport;
        out_data_next.frame_size = view.frame_length;
        out_data_next.protocol_class = cls;
        out_data_next.rtp_sequence = (cls == CLASS_RTP) ? view.rtp_fields[47:32] : 16'd0;
        out_data_next.rtp_time = (cls == CLASS_RTP) ? view.rtp_fields[31:0] : 32'd0;

        if (cls != CLASS_SIP || view.phase == PHASE_SEARCH)
        begin
            out_data_next.call_id_offset = 16'd0;
            out_data_next.call_id_length = 8'd0;
            out_data_next.call_id_status = STATUS_NONE;
        end
        else
        begin
            out_data_next.call_id_offset = view.value_start;
            out_data_next.call_id_length = view.value_count;
            if (view.phase == PHASE_VALUE)
            begin
                out_data_next.call_id_status = STATUS_NO_CRLF;
            end
            else if (view.truncated)
            begin
                out_data_next.call_id_status = STATUS_TRUNCATED;
            end
            else
            begin
                out_data_next.call_id_status = STATUS_FOUND;
            end
        end
    end

    // Output register: a new summary may load in the cycle the old one is taken.
    assign out_free = !out_valid_reg || out_ready;
    assign out_valid_next = load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data = out_data_reg;

endmodule

FILE: dv/voip_packet_header_classifier_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the VoIP packet header classifier: follows the byte, summary and register ports,
// keeps its own model of the frame parser and checks every summary field by field.
// Depends on vphc_pkg for the beat and summary structs and the code constants.
module voip_packet_header_classifier_checker
    import vphc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  in_beat_t    in_data,
    input  logic        out_valid,
    input  logic        out_ready,
    input  summary_t    out_data,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output int unsigned mismatches,
    output int unsigned outstanding
);

    // Mirror of the port registers.
    logic [15:0] sip_port_q;
    logic [15:0] rtp_low_q;
    logic [15:0] rtp_high_q;

    // Mirror of the per-frame parser state.
    logic [15:0] byte_pos;
    logic [3:0]  ihl_words;
    logic [63:0] cap_time;
    logic [15:0] cap_length;
    logic [31:0] ip_src;
    logic [31:0] ip_dst;
    logic [31:0] udp_ports;
    logic [47:0] rtp_hdr;
    logic [63:0] tag_window;
    phase_t      cid_phase;
    logic [15:0] cid_start;
    logic [7:0]  cid_count;
    logic        cid_trunc;

    // Summaries predicted but not yet seen on the output.
    summary_t    summaries_due[$];
    summary_t    want;
    int unsigned errors;
    int unsigned result_index;

    function automatic void clear_frame_state();
        byte_pos   = '0;
        ihl_words  = '0;
        ip_src     = '0;
        ip_dst     = '0;
        udp_ports  = '0;
        rtp_hdr    = '0;
        tag_window = '0;
        cid_phase  = PHASE_SEARCH;
        cid_start  = '0;
        cid_count  = '0;
        cid_trunc  = 1'b0;
    endfunction

    // One more byte of Call-ID value, saturating at the length limit.
    function automatic void count_cid_byte();
        if (cid_count < MAX_CALL_ID_LEN_DEF)
            cid_count++;
        else
            cid_trunc = 1'b1;
    endfunction

    // Place one frame byte into the header, port, RTP and Call-ID trackers.
    function automatic void absorb_byte(input int unsigned pos, input logic [7:0] b);
        int unsigned udp_at;
        int unsigned pay_at;
        logic        prev_cr;
        if (pos == POS_IHL)
            ihl_words = b[3:0];
        if (pos >= POS_SRC_FIRST && pos <= POS_SRC_LAST)
            ip_src[(POS_SRC_LAST - pos) * 8 +: 8] = b;
        if (pos >= POS_DST_FIRST && pos <= POS_DST_LAST)
            ip_dst[(POS_DST_LAST - pos) * 8 +: 8] = b;
        udp_at = POS_IHL + 4 * ihl_words;
        pay_at = udp_at + UDP_HDR_BYTES;
        if (pos >= udp_at && pos < udp_at + 4)
            udp_ports[(udp_at + 3 - pos) * 8 +: 8] = b;
        if (pos < pay_at)
            return;
        if (pos >= pay_at + 2 && pos <= pay_at + 7)
            rtp_hdr[(pay_at + 7 - pos) * 8 +: 8] = b;

        // A CR only ends the value when an LF follows it; a lone CR is a value byte.
        if (cid_phase == PHASE_VALUE) begin
            prev_cr = (tag_window[7:0] == BYTE_CR) && (cid_start <= pos - 1);
            if (prev_cr && b == BYTE_LF) begin
                cid_phase = PHASE_DONE;
            end
            else begin
                if (prev_cr)
                    count_cid_byte();
                if (b != BYTE_CR)
                    count_cid_byte();
            end
        end

        tag_window = {tag_window[55:0], b};
        if (cid_phase == PHASE_SEARCH && tag_window == CALL_ID_TAG) begin
            cid_phase = PHASE_VALUE;
            cid_start = 16'(pos + 1);
        end
    endfunction

    // Build the summary of the frame that has just closed.
    function automatic summary_t close_summary();
        summary_t    s;
        logic [15:0] sp;
        logic [15:0] dp;
        sp = udp_ports[31:16];
        dp = udp_ports[15:0];
        s = '0;
        s.timestamp_us        = cap_time;
        s.source_address      = ip_src;
        s.destination_address = ip_dst;
        s.source_port         = sp;
        s.destination_port    = dp;
        s.frame_size          = cap_length;
        if (sp == sip_port_q || dp == sip_port_q)
            s.protocol_class = CLASS_SIP;
        else if (sp >= rtp_low_q && sp <= rtp_high_q)
            s.protocol_class = CLASS_RTP;
        else
            s.protocol_class = CLASS_UNKNOWN;
        if (s.protocol_class == CLASS_RTP) begin
            s.rtp_sequence = rtp_hdr[47:32];
            s.rtp_time     = rtp_hdr[31:0];
        end
        s.call_id_status = STATUS_NONE;
        if (s.protocol_class == CLASS_SIP && cid_phase != PHASE_SEARCH) begin
            s.call_id_offset = cid_start;
            s.call_id_length = cid_count;
            if (cid_phase == PHASE_VALUE)
                s.call_id_status = STATUS_NO_CRLF;
            else if (cid_trunc)
                s.call_id_status = STATUS_TRUNCATED;
            else
                s.call_id_status = STATUS_FOUND;
        end
        return s;
    endfunction

    // Advance the model by one accepted input beat.
    function automatic void take_beat(input in_beat_t b);
        if (b.first_byte) begin
            clear_frame_state();
            cap_length = b.wire_length;
            cap_time   = 64'(b.ts_seconds) * 64'(US_PER_SEC) + 64'(b.ts_microseconds);
        end
        if (byte_pos < MAX_FRAME_BYTES_DEF) begin
            absorb_byte(byte_pos, b.data_byte);
            byte_pos++;
        end
        if (b.last_byte) begin
            summaries_due.push_back(close_summary());
            clear_frame_state();
        end
    endfunction

    function automatic void check_field(input string name, input logic [63:0] exp_v,
                                        input logic [63:0] act_v);
        if (act_v !== exp_v) begin
            errors++;
            if (errors <= 10)
                $display("summary %0d field %s: expected %h, got %h",
                         result_index, name, exp_v, act_v);
        end
    endfunction

    // Sample all ports on the clock edge, before the edge updates anything.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            sip_port_q   = SIP_PORT_RESET;
            rtp_low_q    = RTP_PORT_LOW_RESET;
            rtp_high_q   = RTP_PORT_HIGH_RESET;
            cap_time     = '0;
            cap_length   = '0;
            clear_frame_state();
            summaries_due.delete();
            errors       = 0;
            result_index = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_SIP_PORT:      sip_port_q = cfg_data;
                    CFG_RTP_PORT_LOW:  rtp_low_q  = cfg_data;
                    CFG_RTP_PORT_HIGH: rtp_high_q = cfg_data;
                    default: ;
                endcase
            end

            // Compare a delivered summary with the oldest prediction.
            if (out_valid && out_ready) begin
                if (summaries_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("summary %0d arrived with none predicted: %h",
                                 result_index, out_data);
                end
                else begin
                    want = summaries_due.pop_front();
                    check_field("timestamp_us", want.timestamp_us, out_data.timestamp_us);
                    check_field("source_address", want.source_address,
                                out_data.source_address);
                    check_field("destination_address", want.destination_address,
                                out_data.destination_address);
                    check_field("source_port", want.source_port, out_data.source_port);
                    check_field("destination_port", want.destination_port,
                                out_data.destination_port);
                    check_field("frame_size", want.frame_size, out_data.frame_size);
                    check_field("protocol_class", want.protocol_class,
                                out_data.protocol_class);
                    check_field("rtp_sequence", want.rtp_sequence, out_data.rtp_sequence);
                    check_field("rtp_time", want.rtp_time, out_data.rtp_time);
                    check_field("call_id_offset", want.call_id_offset,
                                out_data.call_id_offset);
                    check_field("call_id_length", want.call_id_length,
                                out_data.call_id_length);
                    check_field("call_id_status", want.call_id_status,
                                out_data.call_id_status);
                end
                result_index++;
            end

            if (in_valid && in_ready)
                take_beat(in_data);

            mismatches  <= errors;
            outstanding <= summaries_due.size();
        end
    end

endmodule

FILE: dv/voip_packet_header_classifier_tb.sv
`timescale 1ns / 1ps
// Testbench top for the VoIP packet header classifier: clock, reset, frame stimulus and verdict.
// Depends on vphc_pkg, the classifier RTL and voip_packet_header_classifier_checker.
module voip_packet_header_classifier_tb;
    import vphc_pkg::*;

    localparam int unsigned LIMIT_CYCLES    = 2_000_000;
    localparam int unsigned SETTLE_CYCLES   = 8;
    localparam int          FRAME_BUF_BYTES = 65600;

    // How a generated Call-ID value ends.
    localparam int TERM_CRLF = 0;
    localparam int TERM_NONE = 1;
    localparam int TERM_CR   = 2;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_beat_t    in_data;
    logic        out_valid;
    logic        out_ready = 1'b0;
    summary_t    out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    int unsigned fail_count;
    int unsigned expected_left;

    // Stimulus bookkeeping and the port settings currently loaded.
    logic [7:0]  frame_bytes [0:FRAME_BUF_BYTES-1];
    logic [15:0] sip_cfg  = SIP_PORT_RESET;
    logic [15:0] low_cfg  = RTP_PORT_LOW_RESET;
    logic [15:0] high_cfg = RTP_PORT_HIGH_RESET;
    bit          idle_on  = 1'b1;
    int unsigned beats_sent;
    int unsigned summaries_sent;
    int unsigned ready_hold = 0;
    int unsigned cycle_count;

    voip_packet_header_classifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    voip_packet_header_classifier_checker u_scoreboard (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (fail_count),
        .outstanding (expected_left)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // Summary side: ready drops at random while idling is enabled.
    always @(posedge clk)
    begin
        if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0) begin
            out_ready  <= 1'b0;
            ready_hold <= $urandom_range(0, 3);
        end
        else begin
            out_ready <= 1'b1;
        end
    end

    // Offer one byte beat, with an occasional idle burst in front of it.
    task automatic send_beat(input in_beat_t b);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        beats_sent++;
        if (b.last_byte)
            summaries_sent++;
    endtask

    // Send the first len bytes of the frame buffer; side fields ride on the first beat only.
    task automatic send_frame(input int len, input bit with_first, input bit with_last,
                              input logic [15:0] wl, input logic [31:0] sec,
                              input logic [19:0] usec);
        in_beat_t b;
        int       k;
        for (k = 0; k < len; k++) begin
            b.data_byte  = frame_bytes[k];
            b.first_byte = with_first && (k == 0);
            b.last_byte  = with_last && (k == len - 1);
            if (k == 0) begin
                b.wire_length     = wl;
                b.ts_seconds      = sec;
                b.ts_microseconds = usec;
            end
            else begin
                b.wire_length     = 16'($urandom);
                b.ts_seconds      = $urandom;
                b.ts_microseconds = 20'($urandom_range(0, 999999));
            end
            send_beat(b);
        end
    endtask

    task automatic send_closed(input int len);
        send_frame(len, 1'b1, 1'b1, 16'($urandom), $urandom, 20'($urandom_range(0, 999999)));
    endtask

    // Fill the frame buffer: random bytes, IHL, UDP ports and optionally a Call-ID header line.
    // A negative cid_off leaves the tag out.
    task automatic make_frame(input int ihl, input logic [15:0] sp, input logic [15:0] dp,
                              input int cid_off, input int vlen, input int term,
                              input bit cr_inside, input int tail, output int flen);
        int pay;
        int at;
        int k;
        pay  = 22 + 4 * ihl;
        at   = pay + ((cid_off < 0) ? 0 : cid_off);
        flen = (cid_off < 0) ? pay + tail : at + 10 + vlen + tail;
        for (k = 0; k < flen; k++)
            frame_bytes[k] = 8'($urandom_range(0, 255));
        frame_bytes[14]      = {4'h4, 4'(ihl)};
        frame_bytes[pay - 8] = sp[15:8];
        frame_bytes[pay - 7] = sp[7:0];
        frame_bytes[pay - 6] = dp[15:8];
        frame_bytes[pay - 5] = dp[7:0];
        if (cid_off >= 0) begin
            for (k = 0; k < 8; k++)
                frame_bytes[at + k] = CALL_ID_TAG[63 - 8 * k -: 8];
            for (k = 0; k < vlen; k++)
                frame_bytes[at + 8 + k] = 8'($urandom_range(8'h20, 8'h7E));
            if (cr_inside && vlen > 1)
                frame_bytes[at + 8 + $urandom_range(0, vlen - 2)] = BYTE_CR;
            frame_bytes[at + 8 + vlen] = BYTE_CR;
            frame_bytes[at + 9 + vlen] = BYTE_LF;
            if (term == TERM_NONE)
                flen = at + 8 + vlen;
            else if (term == TERM_CR)
                flen = at + 9 + vlen;
        end
    endtask

    function automatic logic [15:0] pick_rtp_port();
        if (low_cfg <= high_cfg)
            return 16'($urandom_range(low_cfg, high_cfg));
        return 16'($urandom);
    endfunction

    // Write all three port registers on consecutive edges.
    task automatic load_ports(input logic [15:0] sip, input logic [15:0] lo,
                              input logic [15:0] hi);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SIP_PORT;
        cfg_data  <= sip;
        @(posedge clk);
        cfg_index <= CFG_RTP_PORT_LOW;
        cfg_data  <= lo;
        @(posedge clk);
        cfg_index <= CFG_RTP_PORT_HIGH;
        cfg_data  <= hi;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sip_cfg  = sip;
        low_cfg  = lo;
        high_cfg = hi;
    endtask

    // Hold the byte stream until every predicted summary is out, then let the pipe settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_left != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic directed_frames();
        int flen;
        int k;
        // One-byte frames with the side fields at both extremes.
        frame_bytes[0] = 8'hFF;
        send_frame(1, 1'b1, 1'b1, 16'hFFFF, 32'hFFFF_FFFF, 20'd999999);
        frame_bytes[0] = 8'h00;
        send_frame(1, 1'b1, 1'b1, 16'h0000, 32'h0000_0000, 20'd0);

        // RTP at both ends of the range, then just outside it.
        make_frame(5, RTP_PORT_LOW_RESET, 16'h0000, -1, 0, TERM_CRLF, 1'b0, 12, flen);
        send_closed(flen);
        make_frame(5, RTP_PORT_HIGH_RESET, 16'hFFFF, -1, 0, TERM_CRLF, 1'b0, 12, flen);
        send_closed(flen);
        make_frame(5, RTP_PORT_LOW_RESET - 16'd1, 16'd7, -1, 0, TERM_CRLF, 1'b0, 9, flen);
        send_closed(flen);
        make_frame(5, RTP_PORT_HIGH_RESET + 16'd1, 16'd7, -1, 0, TERM_CRLF, 1'b0, 9, flen);
        send_closed(flen);

        // SIP on either port; the second also has its source port in the RTP range.
        make_frame(5, SIP_PORT_RESET, 16'd40000, 4, 20, TERM_CRLF, 1'b0, 6, flen);
        send_closed(flen);
        make_frame(5, 16'd20000, SIP_PORT_RESET, 0, 0, TERM_CRLF, 1'b0, 0, flen);
        send_closed(flen);

        // Missing tag, missing CR LF with and without a trailing CR, and a lone CR in the value.
        make_frame(5, SIP_PORT_RESET, 16'd1234, -1, 0, TERM_CRLF, 1'b0, 30, flen);
        send_closed(flen);
        make_frame(5, SIP_PORT_RESET, 16'd1234, 2, 15, TERM_CR, 1'b0, 0, flen);
        send_closed(flen);
        make_frame(5, 16'd1234, SIP_PORT_RESET, 2, 15, TERM_NONE, 1'b0, 0, flen);
        send_closed(flen);
        make_frame(5, SIP_PORT_RESET, 16'd1234, 3, 12, TERM_CRLF, 1'b1, 4, flen);
        send_closed(flen);

        // Value length one past the limit.
        make_frame(5, SIP_PORT_RESET, 16'd99, 0, 256, TERM_CRLF, 1'b0, 2, flen);
        send_closed(flen);

        // Zero bytes ahead of the tag are ordinary payload.
        make_frame(5, SIP_PORT_RESET, 16'd9, 12, 10, TERM_CRLF, 1'b0, 2, flen);
        for (k = 42; k < 54; k++)
            frame_bytes[k] = 8'h00;
        send_closed(flen);

        // A Call-ID in an RTP frame is not reported.
        make_frame(5, 16'd20000, 16'd6000, 0, 8, TERM_CRLF, 1'b0, 0, flen);
        send_closed(flen);

        // Short frames: ending inside the IP header, and right after the UDP ports.
        make_frame(5, 16'd20000, 16'd6000, -1, 0, TERM_CRLF, 1'b0, 12, flen);
        send_closed(30);
        send_closed(38);

        // Smallest and largest IHL.
        make_frame(0, 16'h5000, 16'd6000, -1, 0, TERM_CRLF, 1'b0, 16, flen);
        send_closed(flen);
        make_frame(15, SIP_PORT_RESET, 16'd7, 5, 10, TERM_CRLF, 1'b0, 3, flen);
        send_closed(flen);

        // Frame with no first mark after a summary, then a frame cut off by a new first mark.
        make_frame(5, 16'd20000, 16'd6000, -1, 0, TERM_CRLF, 1'b0, 8, flen);
        send_frame(flen, 1'b0, 1'b1, 16'($urandom), $urandom, 20'($urandom_range(0, 999999)));
        make_frame(5, SIP_PORT_RESET, 16'd1, 0, 30, TERM_CRLF, 1'b0, 0, flen);
        send_frame(50, 1'b1, 1'b0, 16'($urandom), $urandom, 20'($urandom_range(0, 999999)));
        make_frame(5, 16'd20000, 16'd6000, -1, 0, TERM_CRLF, 1'b0, 8, flen);
        send_closed(flen);
    endtask

    // One random frame: mostly well-formed RTP and SIP, the rest odd ports and broken framing.
    task automatic random_frame();
        int          kind;
        int          ihl;
        int          flen;
        int          cid_off;
        int          vlen;
        int          term;
        int          n;
        int          k;
        logic [15:0] sp;
        logic [15:0] dp;
        in_beat_t    b;
        kind = $urandom_range(0, 99);
        ihl  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : 5;
        sp   = 16'($urandom);
        dp   = 16'($urandom);
        if (kind < 40) begin
            sp = pick_rtp_port();
            make_frame(ihl, sp, dp, -1, 0, TERM_CRLF, 1'b0, $urandom_range(0, 40), flen);
            send_closed(flen);
        end
        else if (kind < 75) begin
            if ($urandom_range(0, 1) == 0)
                sp = sip_cfg;
            else
                dp = sip_cfg;
            cid_off = ($urandom_range(0, 9) == 0) ? -1 : $urandom_range(0, 16);
            vlen    = ($urandom_range(0, 15) == 0) ? $urandom_range(250, 300)
                                                   : $urandom_range(0, 40);
            n       = $urandom_range(0, 9);
            term    = (n < 7) ? TERM_CRLF : ((n < 9) ? TERM_NONE : TERM_CR);
            make_frame(ihl, sp, dp, cid_off, vlen, term, $urandom_range(0, 5) == 0,
                       $urandom_range(0, 12), flen);
            send_closed(flen);
        end
        else if (kind < 85) begin
            cid_off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8) : -1;
            make_frame(ihl, sp, dp, cid_off, $urandom_range(0, 20), TERM_CRLF, 1'b0,
                       $urandom_range(0, 30), flen);
            send_closed(flen);
        end
        else begin
            make_frame(ihl, pick_rtp_port(), dp, -1, 0, TERM_CRLF, 1'b0,
                       $urandom_range(0, 20), flen);
            case ($urandom_range(0, 3))
                0: send_closed($urandom_range(1, flen - 1));
                1: send_frame(flen, 1'b0, 1'b1, 16'($urandom), $urandom,
                              20'($urandom_range(0, 999999)));
                2: send_frame($urandom_range(1, flen), 1'b1, 1'b0, 16'($urandom), $urandom,
                              20'($urandom_range(0, 999999)));
                default:
                begin
                    // Loose beats with frame marks at random.
                    n = $urandom_range(1, 20);
                    for (k = 0; k < n; k++) begin
                        b.data_byte       = 8'($urandom);
                        b.first_byte      = ($urandom_range(0, 7) == 0);
                        b.last_byte       = ($urandom_range(0, 7) == 0);
                        b.wire_length     = 16'($urandom);
                        b.ts_seconds      = $urandom;
                        b.ts_microseconds = 20'($urandom_range(0, 999999));
                        send_beat(b);
                    end
                end
            endcase
        end
    endtask

    // Watchdog on the whole run.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    // Reset, directed frames, then random phases over several port settings.
    initial
    begin
        int          phase_no;
        int unsigned beats_mark;
        int unsigned sums_mark;
        logic [15:0] lo;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= CFG_SIP_PORT;
        cfg_data  <= '0;
        beats_sent     = 0;
        summaries_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_frames();
        drain();

        for (phase_no = 0; phase_no < 5; phase_no++) begin
            case (phase_no)
                0: load_ports(16'h0000, 16'h0000, 16'hFFFF);
                1: load_ports(16'hFFFF, 16'd1000, 16'd1000);
                2: load_ports(16'($urandom), 16'd40000, 16'd20000);
                3:
                begin
                    lo = 16'($urandom_range(0, 40000));
                    load_ports(16'($urandom), lo, 16'($urandom_range(lo, 65535)));
                end
                default:
                begin
                    // Final stretch runs at full rate on both sides.
                    idle_on = 1'b0;
                    load_ports(SIP_PORT_RESET, RTP_PORT_LOW_RESET, RTP_PORT_HIGH_RESET);
                end
            endcase
            beats_mark = beats_sent;
            sums_mark  = summaries_sent;
            while (beats_sent - beats_mark < 40 || summaries_sent - sums_mark < 1)
                random_frame();
            drain();
        end

        if (fail_count == 0 && expected_left == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
